FILE: rtl/positional_list_store_defines.svh
// Assertion macros used by the positional list store top level.
// Depends on nothing; files that assert include it by bare name.
`ifndef POSITIONAL_LIST_STORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_DEFINES_SVH

// Check an expression at every clock edge outside reset
`define PLS_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// Check that a condition implies another in the next cycle
`define PLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pls_pkg.sv
// Shared types and constants for the positional list store.
// No dependencies; used by pls_cell and positional_list_store.
`default_nettype none

package pls_pkg;

    localparam int unsigned CAPACITY_DEF = 32;
    localparam int unsigned REQ_W        = 2;
    localparam int unsigned POS_W        = 6;
    localparam int unsigned VAL_W        = 32;
    localparam int unsigned LEN_W        = 6;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_GET    = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

    // Command broadcast from the controller to every cell
    typedef struct packed {
        logic             insert_en;  // open a slot at pos_idx, shift later entries up
        logic             delete_en;  // close the slot at pos_idx, shift later entries down
        logic [POS_W-1:0] pos_idx;    // 0-based target slot
    } cell_op_t;

endpackage

`default_nettype wire

FILE: rtl/positional_list_store.sv
// Top level of the positional list store: request check, cell row, result register.
// Depends on pls_pkg, pls_cell and positional_list_store_defines.svh.
//
//  channel   direction  tdata (low bit up)                                tuser
//  s_axis    in         position[5:0], value[37:6], zero pad [39:38]       req_type[1:0]
//  m_axis    out        status[0], read_value[32:1], list_length[38:33],   none
//                       is_empty[39]
//
// Each request is applied in the cycle it is accepted: all cells shift or load
// together, and the result is captured in the output register at the same edge.
// Throughput is one request per cycle; the output register sets the stall:
// s_axis_tready drops only while a result is held and m_axis_tready is low.
// Reset clears the entry count and the output valid; entry contents are left as is.
`default_nettype none

`include "positional_list_store_defines.svh"

module positional_list_store #(
    parameter int unsigned CAPACITY = pls_pkg::CAPACITY_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // position[5:0], value[37:6], pad
    input  wire logic [1:0]  s_axis_tuser,   // req_type[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [39:0] m_axis_tdata    // status, read_value, list_length, is_empty
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned EW = ((CW > pls_pkg::POS_W) ? CW : pls_pkg::POS_W) + 1;

    logic [pls_pkg::REQ_W-1:0] req_type;
    logic [pls_pkg::POS_W-1:0] position;
    logic [pls_pkg::VAL_W-1:0] value;
    logic                      accept;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [EW-1:0] cnt_ext;
    logic [EW-1:0] pos_ext;
    logic          err;
    logic          rd_en;

    pls_pkg::cell_op_t op;

    logic [pls_pkg::VAL_W-1:0] cell_data [CAPACITY];
    logic [pls_pkg::VAL_W-1:0] cell_hit  [CAPACITY];
    logic [pls_pkg::VAL_W-1:0] hit_or;

    logic                      m_valid_reg;
    logic                      m_valid_next;
    logic                      out_status_reg;
    logic [pls_pkg::VAL_W-1:0] out_value_reg;
    logic [pls_pkg::LEN_W-1:0] out_len_reg;
    logic                      out_empty_reg;

    assign req_type = s_axis_tuser;
    assign position = s_axis_tdata[5:0];
    assign value    = s_axis_tdata[37:6];

    // Take a new transaction whenever the result slot is free or draining
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign cnt_ext = EW'(count_reg);
    assign pos_ext = EW'(position);

    // Check the request against the current length
    always_comb begin
        err   = 1'b0;
        rd_en = 1'b0;
        case (req_type)
            pls_pkg::REQ_INSERT: begin
                err = (cnt_ext >= EW'(CAPACITY)) || (position == '0) ||
                      (pos_ext > cnt_ext + EW'(1));
            end
            pls_pkg::REQ_DELETE, pls_pkg::REQ_GET: begin
                err   = (count_reg == '0) || (position == '0) || (pos_ext > cnt_ext);
                rd_en = !err;
            end
            pls_pkg::REQ_CLEAR: begin
                err = 1'b0;
            end
            default: begin
                err = 1'b1;
            end
        endcase
    end

    // Broadcast the shift command to the cell row
    assign op.insert_en = accept && (req_type == pls_pkg::REQ_INSERT) && !err;
    assign op.delete_en = accept && (req_type == pls_pkg::REQ_DELETE) && !err;
    assign op.pos_idx   = position - pls_pkg::POS_W'(1);

    // Update the length
    always_comb begin
        count_next = count_reg;
        if (accept) begin
            if (op.insert_en) begin
                count_next = count_reg + CW'(1);
            end else if (op.delete_en) begin
                count_next = count_reg - CW'(1);
            end else if (req_type == pls_pkg::REQ_CLEAR) begin
                count_next = '0;
            end
        end
    end

    // Row of cells, each linked to both neighbors
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [pls_pkg::VAL_W-1:0] left_d;
        logic [pls_pkg::VAL_W-1:0] right_d;

        if (i == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        pls_cell #(
            .IDX (i)
        ) u_cell (
            .aclk       (aclk),
            .op         (op),
            .ins_value  (value),
            .left_data  (left_d),
            .right_data (right_d),
            .data_q     (cell_data[i]),
            .hit_data   (cell_hit[i])
        );
    end

    // Merge the addressed cell's entry; at most one cell is hit
    always_comb begin
        hit_or = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            hit_or = hit_or | cell_hit[i];
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_status_reg <= err;
            out_value_reg  <= rd_en ? hit_or : '0;
            out_len_reg    <= pls_pkg::LEN_W'(count_next);
            out_empty_reg  <= (count_next == '0);
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {out_empty_reg, out_len_reg, out_value_reg, out_status_reg};

    // Checks
    `PLS_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(CAPACITY),
        "entry count exceeds capacity")
    `PLS_ASSERT_NEXT(a_insert_grows, op.insert_en, count_reg == $past(count_reg) + CW'(1),
        "successful insert did not grow the list")
    `PLS_ASSERT_NEXT(a_delete_shrinks, op.delete_en, count_reg == $past(count_reg) - CW'(1),
        "successful delete did not shrink the list")
    `PLS_ASSERT_ALWAYS(a_err_no_data, !(m_valid_reg && out_status_reg) || out_value_reg == '0,
        "failed request returned data")

endmodule

`default_nettype wire

FILE: rtl/pls_cell.sv
// One slot of the list: holds an entry and trades it with its neighbors.
// Depends on pls_pkg.
`default_nettype none

module pls_cell #(
    parameter int unsigned IDX = 0
) (
    input  wire logic                      aclk,
    input  wire pls_pkg::cell_op_t         op,
    input  wire logic [pls_pkg::VAL_W-1:0] ins_value,
    input  wire logic [pls_pkg::VAL_W-1:0] left_data,
    input  wire logic [pls_pkg::VAL_W-1:0] right_data,
    output logic      [pls_pkg::VAL_W-1:0] data_q,
    output logic      [pls_pkg::VAL_W-1:0] hit_data
);

    localparam int unsigned IW    = $clog2(IDX + 2);
    localparam int unsigned CMP_W = (IW > pls_pkg::POS_W) ? IW : pls_pkg::POS_W;
    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

    logic [pls_pkg::VAL_W-1:0] data_reg;
    logic [pls_pkg::VAL_W-1:0] data_next;
    logic [CMP_W-1:0]          pos_ext;
    logic                      at_pos;
    logic                      past_pos;

    assign pos_ext  = CMP_W'(op.pos_idx);
    assign at_pos   = (MY_IDX == pos_ext);
    assign past_pos = (MY_IDX > pos_ext);

    // Pick the new entry: own value, neighbor's value or the inserted value
    always_comb begin
        data_next = data_reg;
        if (op.insert_en) begin
            if (at_pos) begin
                data_next = ins_value;
            end else if (past_pos) begin
                data_next = left_data;
            end
        end else if (op.delete_en) begin
            if (at_pos || past_pos) begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_q   = data_reg;
    // Offer the entry to the read reduction when addressed
    assign hit_data = at_pos ? data_reg : '0;

endmodule

`default_nettype wire

FILE: test/list_result_checker.sv
// Checker for the positional list store: watches both stream channels, keeps its own copy of the list.
// Depends on pls_pkg; instantiated beside the block by tb_positional_list_store.
`timescale 1ns / 1ps

module list_result_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // position[5:0], value[37:6], pad
    input  wire logic [1:0]  s_axis_tuser,   // req_type[1:0]
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [39:0] m_axis_tdata,   // status, read_value, list_length, is_empty
    output int               fail_count,
    output int               pending,
    output int               result_count,
    output int               reject_count,
    output int               full_rejects,
    output int               peak_length
);

    // Result word as it leaves the block, lowest field last
    typedef struct packed {
        logic                      is_empty;
        logic [pls_pkg::LEN_W-1:0] list_length;
        logic [pls_pkg::VAL_W-1:0] read_value;
        logic                      status;
    } list_result_t;

    // Shadow of the list contents and its length
    logic [pls_pkg::VAL_W-1:0] slot_word [pls_pkg::CAPACITY_DEF];
    int                        fill = 0;

    list_result_t     pending_results [$];

    // Apply one request to the shadow list and return the result it must produce
    function automatic list_result_t apply_request(input logic [pls_pkg::REQ_W-1:0] req,
                                                   input logic [pls_pkg::POS_W-1:0] pos,
                                                   input logic [pls_pkg::VAL_W-1:0] val);
        list_result_t r;
        int           p;
        int           k;
        r = '0;
        p = int'(pos);
        case (req)
            pls_pkg::REQ_INSERT: begin
                if (fill >= pls_pkg::CAPACITY_DEF || p < 1 || p > fill + 1) begin
                    r.status = 1'b1;
                    if (fill >= pls_pkg::CAPACITY_DEF) full_rejects++;
                end else begin
                    // open a slot: shift later entries up
                    for (k = fill; k > p - 1; k--) slot_word[k] = slot_word[k-1];
                    slot_word[p-1] = val;
                    fill++;
                end
            end
            pls_pkg::REQ_DELETE: begin
                if (fill == 0 || p < 1 || p > fill) begin
                    r.status = 1'b1;
                end else begin
                    r.read_value = slot_word[p-1];
                    // close the gap: shift later entries down
                    for (k = p; k < fill; k++) slot_word[k-1] = slot_word[k];
                    fill--;
                end
            end
            pls_pkg::REQ_GET: begin
                if (fill == 0 || p < 1 || p > fill) r.status = 1'b1;
                else r.read_value = slot_word[p-1];
            end
            pls_pkg::REQ_CLEAR: begin
                fill = 0;
            end
            default: ;
        endcase
        r.list_length = fill[pls_pkg::LEN_W-1:0];
        r.is_empty    = (fill == 0);
        return r;
    endfunction

    task automatic flag_field(input string field, input logic [31:0] want_v,
                              input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s expected %h, got %h", $time, field, want_v, got_v);
            fail_count++;
        end
    endtask

    // Predict on each input transaction, compare on each result transaction
    always @(posedge aclk) begin
        list_result_t want;
        list_result_t got;
        if (!aresetn) begin
            fill = 0;
            pending_results.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                want = apply_request(s_axis_tuser, s_axis_tdata[5:0], s_axis_tdata[37:6]);
                pending_results.push_back(want);
                if (want.status) reject_count++;
                if (fill > peak_length) peak_length = fill;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                result_count++;
                if (pending_results.size() == 0) begin
                    $display("%0t: result expected none, got %h", $time, m_axis_tdata);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    flag_field("status", want.status, got.status);
                    flag_field("read_value", want.read_value, got.read_value);
                    flag_field("list_length", want.list_length, got.list_length);
                    flag_field("is_empty", want.is_empty, got.is_empty);
                end
            end
        end
        pending = pending_results.size();
    end

endmodule

FILE: test/tb_positional_list_store.sv
// Testbench top for the positional list store: clock, reset, request stimulus and verdict.
// Depends on pls_pkg, positional_list_store and list_result_checker.
`timescale 1ns / 1ps

module tb_positional_list_store;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;   // position[5:0], value[37:6], pad
    logic [1:0]  s_axis_tuser  = '0;   // req_type[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // status, read_value, list_length, is_empty

    int          fail_count;
    int          pending;
    int          result_count;
    int          reject_count;
    int          full_rejects;
    int          peak_length;

    // Stimulus-side view of the list length, used only to aim positions
    int          list_len      = 0;
    int          request_count = 0;
    bit          no_idle       = 1'b0;

    positional_list_store uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    list_result_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .result_count  (result_count),
        .reject_count  (reject_count),
        .full_rejects  (full_rejects),
        .peak_length   (peak_length)
    );

    always #10 aclk = ~aclk;

    // Send one request; valid stays high across back-to-back transactions
    task automatic send_request(input logic [pls_pkg::REQ_W-1:0] req, input int pos,
                                input logic [pls_pkg::VAL_W-1:0] val);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {2'b00, val, pos[pls_pkg::POS_W-1:0]};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        request_count++;
        // track the length to aim later positions
        case (req)
            pls_pkg::REQ_INSERT:
                if (list_len < pls_pkg::CAPACITY_DEF && pos >= 1 && pos <= list_len + 1)
                    list_len++;
            pls_pkg::REQ_DELETE: if (list_len > 0 && pos >= 1 && pos <= list_len) list_len--;
            pls_pkg::REQ_CLEAR:  list_len = 0;
            default:    ;
        endcase
    endtask

    // Mostly a legal position in 1..hi, sometimes one just outside or anywhere
    function automatic int pick_pos(input int hi);
        int roll;
        roll = $urandom_range(0, 99);
        if (hi >= 1 && roll < 85) return $urandom_range(1, hi);
        if (roll < 90) return 0;
        if (roll < 95) return (hi + 1 > 63) ? 63 : hi + 1;
        return $urandom_range(0, 63);
    endfunction

    function automatic logic [pls_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Result side: random stall before each result, with quiet stretches
    initial begin
        int stall;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
            while (!m_axis_tvalid) @(posedge aclk);
        end
    end

    // Stimulus and verdict
    initial begin
        int phase_left;
        int profile;
        int roll;
        int ins_pct;
        int del_pct;
        int drain;
        phase_left = 0;
        profile    = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty-list errors, bad positions, front/middle/end edits, clear
        send_request(pls_pkg::REQ_GET, 1, 32'h1234_5678);
        send_request(pls_pkg::REQ_DELETE, 0, 32'h0);
        send_request(pls_pkg::REQ_CLEAR, 0, 32'h0);
        send_request(pls_pkg::REQ_INSERT, 0, 32'hdead_beef);
        send_request(pls_pkg::REQ_INSERT, 2, 32'hdead_beef);
        send_request(pls_pkg::REQ_INSERT, 1, 32'h8000_0000);
        send_request(pls_pkg::REQ_INSERT, 2, 32'h7fff_ffff);
        send_request(pls_pkg::REQ_INSERT, 1, 32'hffff_ffff);
        send_request(pls_pkg::REQ_INSERT, 2, 32'h0000_0000);
        send_request(pls_pkg::REQ_GET, 1, 32'h0);
        send_request(pls_pkg::REQ_GET, 4, 32'h0);
        send_request(pls_pkg::REQ_GET, 5, 32'h0);
        send_request(pls_pkg::REQ_GET, 63, 32'hffff_ffff);
        send_request(pls_pkg::REQ_GET, 0, 32'h0);
        send_request(pls_pkg::REQ_INSERT, 6, 32'h1111_1111);
        send_request(pls_pkg::REQ_INSERT, 63, 32'h2222_2222);
        send_request(pls_pkg::REQ_DELETE, 5, 32'h0);
        send_request(pls_pkg::REQ_DELETE, 0, 32'h0);
        send_request(pls_pkg::REQ_DELETE, 2, 32'h0);
        send_request(pls_pkg::REQ_DELETE, 3, 32'h0);
        send_request(pls_pkg::REQ_DELETE, 1, 32'h0);
        send_request(pls_pkg::REQ_INSERT, 2, 32'h5555_5555);
        send_request(pls_pkg::REQ_CLEAR, 42, 32'haaaa_aaaa);
        send_request(pls_pkg::REQ_GET, 1, 32'h0);
        send_request(pls_pkg::REQ_DELETE, 1, 32'h0);

        // random: phases that grow, shrink or churn the list; first one fills it
        for (int n = 0; n < 1425; n++) begin
            if (phase_left == 0) begin
                profile    = (n == 0) ? 0 : $urandom_range(0, 2);
                phase_left = (n == 0) ? 80 : $urandom_range(30, 80);
                no_idle    = ($urandom_range(0, 4) == 0);
            end
            phase_left--;
            case (profile)
                0:       begin ins_pct = 70; del_pct = 10; end
                1:       begin ins_pct = 15; del_pct = 60; end
                default: begin ins_pct = 35; del_pct = 30; end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < ins_pct)
                send_request(pls_pkg::REQ_INSERT, pick_pos(list_len + 1), pick_value());
            else if (roll < ins_pct + del_pct)
                send_request(pls_pkg::REQ_DELETE, pick_pos(list_len), $urandom());
            else if (roll < 98)
                send_request(pls_pkg::REQ_GET, pick_pos(list_len), $urandom());
            else
                send_request(pls_pkg::REQ_CLEAR, $urandom_range(0, 63), $urandom());
        end
        s_axis_tvalid <= 1'b0;

        // drain outstanding results, then let the output register settle
        drain = 0;
        while (pending != 0 && drain < 1000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (4) @(posedge aclk);

        $display("Ran %0d requests, checked %0d results, %0d refused (%0d on a full list).",
                 request_count, result_count, reject_count, full_rejects);
        $display("Longest list reached %0d entries.", peak_length);
        if (fail_count == 0 && pending == 0) begin
            $display("positional_list_store: match");
        end else begin
            $display("positional_list_store: mismatch");
        end
        $finish;
    end

    // Hard stop if the handshakes hang
    initial begin
        #5_000_000;
        $display("positional_list_store: mismatch");
        $finish;
    end

endmodule
